FILE: src/asrb_pkg.sv
// Package: shared types, constants and helpers for the split ratio balancer.
`default_nettype none

package asrb_pkg;

  // Share limits in Q0.16
  localparam logic [15:0] SHARE_MIN = 16'd3277;
  localparam logic [15:0] SHARE_MAX = 16'd62259;
  localparam logic [15:0] SHARE_ONE = 16'd65535;

  // Tiles per ms scale: 1000 us per ms
  localparam logic [9:0] US_PER_MS = 10'd1000;

  // Execution modes
  localparam logic [1:0] MODE_CPU      = 2'd0;
  localparam logic [1:0] MODE_GPU      = 2'd1;
  localparam logic [1:0] MODE_FIXED    = 2'd2;
  localparam logic [1:0] MODE_ADAPTIVE = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_INIT     = 3'd1;
  localparam logic [2:0] REG_INTERVAL = 3'd2;
  localparam logic [2:0] REG_DEADBAND = 3'd3;
  localparam logic [2:0] REG_MAXSTEP  = 3'd4;

  // Divider widths
  localparam int REM_W = 33;
  localparam int LOW_W = 32;
  localparam int CNT_W = 6;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [REM_W-1:0] rem;   // upper part of dividend, below den
    logic [LOW_W-1:0] low;   // remaining dividend bits, left aligned
    logic [REM_W-1:0] den;
    logic [CNT_W-1:0] steps; // quotient bits to produce
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [LOW_W-1:0] quo;
  } div_rsp_t;

  // Share after (re)initialisation for a given mode
  function automatic logic [15:0] init_share(input logic [1:0] mode, input logic [15:0] ratio);
    logic [15:0] r;
    begin
      r = ratio;
      if (mode == MODE_CPU) begin
        r = 16'd0;
      end else if (mode == MODE_GPU) begin
        r = SHARE_ONE;
      end else if (ratio < SHARE_MIN) begin
        r = SHARE_MIN;
      end else if (ratio > SHARE_MAX) begin
        r = SHARE_MAX;
      end
      return r;
    end
  endfunction

endpackage

`default_nettype wire

FILE: src/asrb_if.sv
// Interfaces: frame report channel and share result channel.
`default_nettype none

interface asrb_frame_if;
  logic        valid;
  logic        ready;
  logic [15:0] cpu_tile_count;
  logic [23:0] cpu_time_us;
  logic [15:0] gpu_tile_count;
  logic [23:0] gpu_time_us;

  modport source (output valid, output cpu_tile_count, output cpu_time_us,
                  output gpu_tile_count, output gpu_time_us, input ready);
  modport sink   (input valid, input cpu_tile_count, input cpu_time_us,
                  input gpu_tile_count, input gpu_time_us, output ready);
endinterface

interface asrb_share_if;
  logic        valid;
  logic        ready;
  logic [15:0] gpu_share;
  logic        share_changed;

  modport source (output valid, output gpu_share, output share_changed, input ready);
  modport sink   (input valid, input gpu_share, input share_changed, output ready);
endinterface

`default_nettype wire

FILE: src/asrb_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module asrb_div
  import asrb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [REM_W-1:0] rem;
  logic [LOW_W-1:0] low;
  logic [REM_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  // One trial subtraction
  logic [REM_W:0]   cand;
  logic [REM_W:0]   diff;
  logic             ge;
  logic [REM_W-1:0] rem_next;

  always_comb begin
    cand     = {rem, low[LOW_W-1]};
    diff     = cand - {1'b0, den};
    ge       = (cand >= {1'b0, den});
    rem_next = ge ? diff[REM_W-1:0] : cand[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        rem  <= req.rem;
        low  <= req.low;
        den  <= req.den;
        cnt  <= req.steps;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        low <= {low[LOW_W-2:0], ge};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = low;

endmodule

`default_nettype wire

FILE: src/adaptive_split_ratio_balancer_top.sv
// Top level: split ratio balancer with APB register port and sequencer.
// In adaptive mode a word runs two rate divides (32 quotient bits each) and one target
//   divide (16 quotient bits), all on the shared divider; a rate divide is left out
//   when its sample is skipped or saturated, the target divide with the adjustment.
// Other modes go straight to emit. A word is taken in idle, also while a result waits.
// Reset: synchronous, active high; defaults loaded, estimates and phase cleared.
`default_nettype none

module adaptive_split_ratio_balancer_top
  import asrb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  asrb_frame_if.sink       frame,
  asrb_share_if.source     result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_PROD   = 11'b000_0000_0010,
    S_DSTART = 11'b000_0000_0100,
    S_DWAIT  = 11'b000_0000_1000,
    S_EWMA   = 11'b000_0001_0000,
    S_PHASE  = 11'b000_0010_0000,
    S_TSTART = 11'b000_0100_0000,
    S_TWAIT  = 11'b000_1000_0000,
    S_ADJ1   = 11'b001_0000_0000,
    S_ADJ2   = 11'b010_0000_0000,
    S_EMIT   = 11'b100_0000_0000
  } state_t;

  // Configuration registers
  logic [1:0]  exec_mode;
  logic [15:0] initial_ratio;
  logic [15:0] adj_period;
  logic [15:0] deadband;
  logic [15:0] max_step;

  // Block state
  logic [31:0] cpu_est;
  logic [31:0] gpu_est;
  logic [15:0] frame_phase;
  logic [15:0] share;

  // Sequencer and working registers
  state_t      state;
  logic        eng;
  logic [15:0] cpu_cnt;
  logic [23:0] cpu_time;
  logic [15:0] gpu_cnt;
  logic [23:0] gpu_time;
  logic [15:0] share_before;
  logic [25:0] prod;
  logic [31:0] sample;
  logic [15:0] target;
  logic signed [17:0] delta;
  logic        adj;

  logic        out_valid;
  logic [15:0] out_share;
  logic        out_changed;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  asrb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // APB decode
  logic       cfg_wr;
  logic [2:0] cfg_idx;
  logic       cfg_hit;
  logic [1:0] mode_next;
  logic [15:0] init_next;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];
  assign cfg_hit = cfg_wr && (cfg_idx <= REG_MAXSTEP);

  always_comb begin
    mode_next = exec_mode;
    init_next = initial_ratio;
    if (cfg_wr && cfg_idx == REG_MODE) begin
      mode_next = pwdata[1:0];
    end
    if (cfg_wr && cfg_idx == REG_INIT) begin
      init_next = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exec_mode     <= MODE_ADAPTIVE;
      initial_ratio <= 16'd32768;
      adj_period    <= 16'd1;
      deadband      <= 16'd1966;
      max_step      <= 16'd6554;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:     exec_mode     <= pwdata[1:0];
        REG_INIT:     initial_ratio <= pwdata[15:0];
        REG_INTERVAL: adj_period    <= pwdata[15:0];
        REG_DEADBAND: deadband      <= pwdata[15:0];
        REG_MAXSTEP:  max_step      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (cfg_idx)
      REG_MODE:     prdata = {30'd0, exec_mode};
      REG_INIT:     prdata = {16'd0, initial_ratio};
      REG_INTERVAL: prdata = {16'd0, adj_period};
      REG_DEADBAND: prdata = {16'd0, deadband};
      REG_MAXSTEP:  prdata = {16'd0, max_step};
      default:      prdata = 32'd0;
    endcase
  end

  // Selected engine
  logic [15:0] sel_tiles;
  logic [23:0] sel_time;
  logic [31:0] sel_est;

  assign sel_tiles = eng ? gpu_cnt  : cpu_cnt;
  assign sel_time  = eng ? gpu_time : cpu_time;
  assign sel_est   = eng ? gpu_est  : cpu_est;

  // Rate sample overflow: dividend bits above 32 against the time
  logic sample_sat;
  assign sample_sat = ({14'd0, prod[25:16]} >= sel_time);

  // EWMA, alpha 1/4
  logic [33:0] ewma_sum;
  logic [31:0] est_new;
  always_comb begin
    ewma_sum = {2'b00, sample} + {2'b00, sel_est} + {1'b0, sel_est, 1'b0};
    est_new  = (sel_est == 32'd0) ? sample : ewma_sum[33:2];
  end

  // Phase counter
  logic [15:0] interval;
  logic [16:0] phase_inc;
  assign interval  = (adj_period == 16'd0) ? 16'd1 : adj_period;
  assign phase_inc = {1'b0, frame_phase} + 17'd1;

  // Difference to the target, its magnitude for the deadband, step limited to max_step
  logic signed [17:0] diff;
  logic signed [17:0] mag;
  logic signed [17:0] ms;
  logic signed [17:0] step;
  always_comb begin
    diff = $signed({2'b00, target}) - $signed({2'b00, share});
    mag  = (diff < 0) ? -diff : diff;
    ms   = $signed({2'b00, max_step});
    priority if (diff > ms) begin
      step = ms;
    end else if (diff < -ms) begin
      step = -ms;
    end else begin
      step = diff;
    end
  end

  // New share, clamped to the band
  logic signed [17:0] moved;
  logic [15:0]        share_adj;
  always_comb begin
    moved = $signed({2'b00, share}) + delta;
    priority if (moved < $signed({2'b00, SHARE_MIN})) begin
      share_adj = SHARE_MIN;
    end else if (moved > $signed({2'b00, SHARE_MAX})) begin
      share_adj = SHARE_MAX;
    end else begin
      share_adj = moved[15:0];
    end
  end

  // Divider requests
  always_comb begin
    div_req       = '0;
    div_req.start = 1'b0;
    if (state == S_DSTART) begin
      div_req.start = !(sel_tiles == 16'd0 || sel_time == 24'd0) && !sample_sat;
      div_req.rem   = {23'd0, prod[25:16]};
      div_req.low   = {prod[15:0], 16'd0};
      div_req.den   = {9'd0, sel_time};
      div_req.steps = CNT_W'(32);
    end else if (state == S_TSTART) begin
      div_req.start = 1'b1;
      div_req.rem   = {1'b0, gpu_est};
      div_req.low   = '0;
      div_req.den   = {1'b0, cpu_est} + {1'b0, gpu_est};
      div_req.steps = CNT_W'(16);
    end
  end

  // No word is taken while a register write reinitialises the state
  assign frame.ready = (state == S_IDLE) && !cfg_hit;

  // Result word leaves emit once the output register is free and no register write hits
  logic emit_go;
  assign emit_go = (state == S_EMIT) && !cfg_hit && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer and state update
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      eng         <= 1'b0;
      cpu_est     <= '0;
      gpu_est     <= '0;
      frame_phase <= '0;
      share       <= init_share(MODE_ADAPTIVE, 16'd32768);
      adj         <= 1'b0;
    end else begin
      if (cfg_hit) begin
        cpu_est     <= '0;
        gpu_est     <= '0;
        frame_phase <= '0;
        share       <= init_share(mode_next, init_next);
      end else begin
        unique case (state)
          S_IDLE: begin
            if (frame.valid) begin
              cpu_cnt      <= frame.cpu_tile_count;
              cpu_time     <= frame.cpu_time_us;
              gpu_cnt      <= frame.gpu_tile_count;
              gpu_time     <= frame.gpu_time_us;
              share_before <= share;
              eng          <= 1'b0;
              state        <= (exec_mode == MODE_ADAPTIVE) ? S_PROD : S_EMIT;
            end
          end
          S_PROD: begin
            prod  <= {10'd0, sel_tiles} * {16'd0, US_PER_MS};
            state <= S_DSTART;
          end
          S_DSTART: begin
            if (sel_tiles == 16'd0 || sel_time == 24'd0) begin
              eng   <= 1'b1;
              state <= eng ? S_PHASE : S_PROD;
            end else if (sample_sat) begin
              sample <= 32'hFFFF_FFFF;
              state  <= S_EWMA;
            end else begin
              state <= S_DWAIT;
            end
          end
          S_DWAIT: begin
            if (div_rsp.done) begin
              sample <= div_rsp.quo;
              state  <= S_EWMA;
            end
          end
          S_EWMA: begin
            if (eng) begin
              gpu_est <= est_new;
              state   <= S_PHASE;
            end else begin
              cpu_est <= est_new;
              eng     <= 1'b1;
              state   <= S_PROD;
            end
          end
          S_PHASE: begin
            if (phase_inc >= {1'b0, interval}) begin
              frame_phase <= '0;
              state <= (cpu_est != 32'd0 && gpu_est != 32'd0) ? S_TSTART : S_EMIT;
            end else begin
              frame_phase <= phase_inc[15:0];
              state       <= S_EMIT;
            end
          end
          S_TSTART: begin
            state <= S_TWAIT;
          end
          S_TWAIT: begin
            if (div_rsp.done) begin
              target <= div_rsp.quo[15:0];
              state  <= S_ADJ1;
            end
          end
          S_ADJ1: begin
            adj   <= (mag >= $signed({2'b00, deadband}));
            delta <= step;
            state <= S_ADJ2;
          end
          S_ADJ2: begin
            if (adj) begin
              share <= share_adj;
            end
            state <= S_EMIT;
          end
          S_EMIT: begin
            if (emit_go) begin
              out_share   <= share;
              out_changed <= (share != share_before);
              state       <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  assign result.valid         = out_valid;
  assign result.gpu_share     = out_share;
  assign result.share_changed = out_changed;

  // Checks
  a_share_band: assert property (@(posedge clk) disable iff (rst)
    (exec_mode == MODE_ADAPTIVE && state == S_IDLE) |->
      (share >= SHARE_MIN && share <= SHARE_MAX))
    else $error("adaptive share outside band");

  a_div_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_emit_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == S_EMIT))
    else $error("result word not from emit step");

  a_changed_mode: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.share_changed) |-> exec_mode == MODE_ADAPTIVE)
    else $error("share changed outside adaptive mode");

endmodule

`default_nettype wire

FILE: dv/tb_adaptive_split_ratio_balancer_top.sv
// Testbench for the split ratio balancer: predicted shares checked against every result word.
`default_nettype none

module tb_adaptive_split_ratio_balancer_top;
  import asrb_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 120;
  localparam logic [2:0] REG_SPARE = 3'd5;  // not a listed register

  typedef struct packed {
    logic [15:0] cpu_tile_count;
    logic [23:0] cpu_time_us;
    logic [15:0] gpu_tile_count;
    logic [23:0] gpu_time_us;
  } frame_t;

  typedef struct packed {
    logic [15:0] gpu_share;
    logic        share_changed;
  } share_word_t;

  // Share predictor and queue of awaited result words
  class share_scoreboard;
    logic [1:0]  mode;
    logic [15:0] start_ratio;
    logic [15:0] interval;
    logic [15:0] deadband;
    logic [15:0] max_step;
    logic [31:0] cpu_rate;
    logic [31:0] gpu_rate;
    logic [15:0] phase;
    logic [15:0] share;
    share_word_t awaited[$];
    int          errors;

    function new();
      mode        = MODE_ADAPTIVE;
      start_ratio = 16'd32768;
      interval    = 16'd1;
      deadband    = 16'd1966;
      max_step    = 16'd6554;
      errors      = 0;
      restart();
    endfunction

    // Estimates and phase clear; share follows the mode
    function void restart();
      cpu_rate = '0;
      gpu_rate = '0;
      phase    = '0;
      case (mode)
        MODE_CPU: share = 16'd0;
        MODE_GPU: share = SHARE_ONE;
        default: begin
          if (start_ratio < SHARE_MIN) share = SHARE_MIN;
          else if (start_ratio > SHARE_MAX) share = SHARE_MAX;
          else share = start_ratio;
        end
      endcase
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_MODE:     mode        = val[1:0];
        REG_INIT:     start_ratio = val[15:0];
        REG_INTERVAL: interval    = val[15:0];
        REG_DEADBAND: deadband    = val[15:0];
        REG_MAXSTEP:  max_step    = val[15:0];
        default: return;
      endcase
      restart();
    endfunction

    // Tiles per ms in Q16.16, blended into the estimate with weight 1/4
    function logic [31:0] smooth_rate(logic [31:0] est, logic [15:0] tiles, logic [23:0] us);
      logic [63:0] sample;
      if (tiles == 16'd0 || us == 24'd0) return est;
      sample = ({48'd0, tiles} * 64'd65536000) / {40'd0, us};
      if (sample > 64'hFFFF_FFFF) sample = 64'hFFFF_FFFF;
      if (est == 32'd0) return sample[31:0];
      sample = (sample + 64'd3 * {32'd0, est}) >> 2;
      return sample[31:0];
    endfunction

    function void note_frame(frame_t f);
      share_word_t w;
      logic [15:0] prior;
      logic [15:0] span;
      logic [16:0] next_phase;
      logic [63:0] target;
      int          diff;
      int          mag;
      int          limit;
      int          moved;
      prior = share;
      if (mode == MODE_ADAPTIVE) begin
        cpu_rate   = smooth_rate(cpu_rate, f.cpu_tile_count, f.cpu_time_us);
        gpu_rate   = smooth_rate(gpu_rate, f.gpu_tile_count, f.gpu_time_us);
        span       = (interval == 16'd0) ? 16'd1 : interval;
        next_phase = {1'b0, phase} + 17'd1;
        if (next_phase >= {1'b0, span}) begin
          phase = '0;
          if (cpu_rate != 32'd0 && gpu_rate != 32'd0) begin
            target = {16'd0, gpu_rate, 16'd0} / ({32'd0, cpu_rate} + {32'd0, gpu_rate});
            if (target > {48'd0, SHARE_ONE}) target = {48'd0, SHARE_ONE};
            diff  = int'({16'd0, target[15:0]}) - int'({16'd0, share});
            mag   = (diff < 0) ? -diff : diff;
            limit = int'({16'd0, max_step});
            if (mag >= int'({16'd0, deadband})) begin
              if (diff > limit) diff = limit;
              if (diff < -limit) diff = -limit;
              moved = int'({16'd0, share}) + diff;
              if (moved < int'({16'd0, SHARE_MIN})) share = SHARE_MIN;
              else if (moved > int'({16'd0, SHARE_MAX})) share = SHARE_MAX;
              else share = moved[15:0];
            end
          end
        end else begin
          phase = next_phase[15:0];
        end
      end
      w.gpu_share     = share;
      w.share_changed = (share != prior);
      awaited.push_back(w);
    endfunction

    task report(string what);
      errors++;
      $display("%0t mismatch: %s", $realtime, what);
    endtask

    task check_share(logic [15:0] gpu_share, logic share_changed);
      share_word_t w;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected word share=%0d changed=%0b", gpu_share, share_changed));
        return;
      end
      w = awaited.pop_front();
      if (gpu_share !== w.gpu_share)
        report($sformatf("gpu_share %0d, want %0d", gpu_share, w.gpu_share));
      if (share_changed !== w.share_changed)
        report($sformatf("share_changed %0b, want %0b", share_changed, w.share_changed));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int src_idle_pct;
  int stall_pct;
  int hold_requests;
  int holds_served;
  int hold_left;
  int cycle_count;

  share_scoreboard sb;

  asrb_frame_if frame_bus();
  asrb_share_if share_bus();

  adaptive_split_ratio_balancer_top uut (
    .clk     (clk),
    .rst     (rst),
    .frame   (frame_bus),
    .result  (share_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random stalls, plus long hold-offs on request
  initial begin
    share_bus.ready = 1'b0;
    hold_left       = 0;
    holds_served    = 0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        share_bus.ready = 1'b0;
      end else begin
        share_bus.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && share_bus.valid && share_bus.ready)
      sb.check_share(share_bus.gpu_share, share_bus.share_changed);
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_adaptive_split_ratio_balancer_top: FAIL");
    $finish;
  end

  function automatic frame_t mk_frame(int ct, int cu, int gt, int gu);
    frame_t f;
    f.cpu_tile_count = ct[15:0];
    f.cpu_time_us    = cu[23:0];
    f.gpu_tile_count = gt[15:0];
    f.gpu_time_us    = gu[23:0];
    return f;
  endfunction

  // Mostly plausible frame reports; some raw noise and some with a zero field
  function automatic frame_t random_frame();
    frame_t f;
    int     pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      f = mk_frame($urandom_range(1, 65535), $urandom_range(1, 2000000),
                   $urandom_range(1, 65535), $urandom_range(1, 2000000));
    end else begin
      f = mk_frame($urandom_range(1, 3000), $urandom_range(20, 150000),
                   $urandom_range(1, 3000), $urandom_range(20, 150000));
    end
    if (pick >= 80 && pick < 90) begin
      f = mk_frame($urandom_range(0, 32'hFFFF), $urandom_range(0, 32'hFF_FFFF),
                   $urandom_range(0, 32'hFFFF), $urandom_range(0, 32'hFF_FFFF));
    end else if (pick >= 90) begin
      case ($urandom_range(3))
        0: f.cpu_tile_count = '0;
        1: f.cpu_time_us    = '0;
        2: f.gpu_tile_count = '0;
        default: f.gpu_time_us = '0;
      endcase
    end
    return f;
  endfunction

  // Offer one frame word; called and left at a falling edge
  task offer_frame(frame_t f);
    while ($urandom_range(99) < src_idle_pct) begin
      frame_bus.valid = 1'b0;
      @(negedge clk);
    end
    frame_bus.cpu_tile_count = f.cpu_tile_count;
    frame_bus.cpu_time_us    = f.cpu_time_us;
    frame_bus.gpu_tile_count = f.gpu_tile_count;
    frame_bus.gpu_time_us    = f.gpu_time_us;
    frame_bus.valid          = 1'b1;
    do @(posedge clk); while (!frame_bus.ready);
    sb.note_frame(f);
    @(negedge clk);
  endtask

  task wait_results_done();
    frame_bus.valid = 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB write, only once the block has gone idle
  task write_reg(logic [2:0] idx, logic [31:0] val);
    wait_results_done();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task set_config(logic [1:0] mode, int ratio, int ival, int band, int step);
    write_reg(REG_MODE, {30'd0, mode});
    write_reg(REG_INIT, ratio);
    write_reg(REG_INTERVAL, ival);
    write_reg(REG_DEADBAND, band);
    write_reg(REG_MAXSTEP, step);
  endtask

  task run_random(int count, int hold_at, int drain_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_requests++;
      if (i == drain_at) wait_results_done();
      offer_frame(random_frame());
    end
  endtask

  initial begin
    sb                       = new();
    rst                      = 1'b1;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = '0;
    pwdata                   = '0;
    frame_bus.valid          = 1'b0;
    frame_bus.cpu_tile_count = '0;
    frame_bus.cpu_time_us    = '0;
    frame_bus.gpu_tile_count = '0;
    frame_bus.gpu_time_us    = '0;
    src_idle_pct             = 0;
    stall_pct                = 0;
    hold_requests            = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset defaults: missing cpu estimate, zero time, equal rates, then saturated rates
    offer_frame(mk_frame(0, 500, 300, 500));
    offer_frame(mk_frame(200, 0, 300, 500));
    offer_frame(mk_frame(300, 500, 300, 500));
    offer_frame(mk_frame(1, 24'hFF_FFFF, 16'hFFFF, 1));
    offer_frame(mk_frame(1, 24'hFF_FFFF, 16'hFFFF, 1));
    offer_frame(mk_frame(16'hFFFF, 1, 1, 24'hFF_FFFF));

    // Zero interval adjusts every frame; interval of three only on the wrap
    write_reg(REG_INTERVAL, 0);
    offer_frame(mk_frame(900, 1000, 100, 1000));
    offer_frame(mk_frame(900, 1000, 100, 1000));
    write_reg(REG_INTERVAL, 3);
    offer_frame(mk_frame(100, 1000, 900, 1000));
    offer_frame(mk_frame(100, 1000, 900, 1000));
    offer_frame(mk_frame(100, 1000, 900, 1000));

    // No deadband with a zero step, then an unlimited step to both clamps
    set_config(MODE_ADAPTIVE, 32768, 1, 0, 0);
    offer_frame(mk_frame(10, 1000, 900, 1000));
    write_reg(REG_MAXSTEP, 16'hFFFF);
    offer_frame(mk_frame(16'hFFFF, 1, 1, 24'hFF_FFFF));
    offer_frame(mk_frame(1, 24'hFF_FFFF, 16'hFFFF, 1));
    write_reg(REG_DEADBAND, 16'hFFFF);
    offer_frame(mk_frame(1, 24'hFF_FFFF, 16'hFFFF, 1));

    // Constant-share modes, start ratio clamps, unlisted register, garbage upper bits
    write_reg(REG_MODE, {30'd0, MODE_CPU});
    offer_frame(mk_frame(500, 1000, 500, 1000));
    write_reg(REG_MODE, {30'd0, MODE_GPU});
    offer_frame(mk_frame(500, 1000, 500, 1000));
    write_reg(REG_MODE, {30'd0, MODE_FIXED});
    write_reg(REG_INIT, 0);
    offer_frame(mk_frame(500, 1000, 500, 1000));
    write_reg(REG_INIT, 32'hFFFF_FFFF);
    write_reg(REG_SPARE, 32'hDEAD_BEEF);
    offer_frame(mk_frame(500, 1000, 500, 1000));
    write_reg(REG_MODE, {30'h3FFF_FFFF, MODE_ADAPTIVE});
    offer_frame(mk_frame(1, 24'hFF_FFFF, 16'hFFFF, 1));

    // Random phases over several settings and idling patterns
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin
          set_config(MODE_ADAPTIVE, 32768, 1, 1966, 6554);
          src_idle_pct = 0;  stall_pct = 0;
          run_random(70, 5, -1);
        end
        1: begin
          set_config(MODE_ADAPTIVE, $urandom_range(0, 65535), 2,
                     $urandom_range(0, 3000), $urandom_range(1, 12000));
          src_idle_pct = 63; stall_pct = 0;
          run_random(70, -1, 35);
        end
        2: begin
          set_config(MODE_ADAPTIVE, 0, 1, 0, 16'hFFFF);
          src_idle_pct = 0;  stall_pct = 63;
          run_random(70, -1, -1);
        end
        3: begin
          set_config(MODE_ADAPTIVE, $urandom_range(0, 65535), $urandom_range(3, 6), 300, 2000);
          src_idle_pct = 28; stall_pct = 28;
          run_random(70, 0, -1);
        end
        4: begin
          set_config(MODE_FIXED, $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535));
          src_idle_pct = 0;  stall_pct = 0;
          run_random(12, -1, -1);
        end
        5: begin
          set_config(MODE_GPU, $urandom_range(0, 65535), 1, 0, 16'hFFFF);
          src_idle_pct = 28; stall_pct = 28;
          run_random(6, -1, -1);
        end
        6: begin
          set_config(MODE_CPU, $urandom_range(0, 65535), 1, 0, 16'hFFFF);
          src_idle_pct = 0;  stall_pct = 63;
          run_random(6, -1, -1);
        end
        7: begin
          set_config(MODE_ADAPTIVE, $urandom_range(0, 65535), 16'hFFFF,
                     $urandom_range(0, 2000), $urandom_range(0, 65535));
          src_idle_pct = 28; stall_pct = 28;
          run_random(30, -1, -1);
        end
        8: begin
          set_config(MODE_ADAPTIVE, 16'hFFFF, 0, $urandom_range(0, 500), $urandom_range(0, 65535));
          src_idle_pct = 28; stall_pct = 28;
          run_random(120, 60, 100);
        end
        default: begin
          set_config(MODE_ADAPTIVE, $urandom_range(0, 65535), 1,
                     $urandom_range(0, 1000), $urandom_range(500, 8000));
          src_idle_pct = 0;  stall_pct = 0;
          run_random(80, -1, -1);
        end
      endcase
    end

    // Let the last words drain out
    frame_bus.valid = 1'b0;
    stall_pct       = 0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.awaited.size() == 0)
      $display("tb_adaptive_split_ratio_balancer_top: PASS");
    else
      $display("tb_adaptive_split_ratio_balancer_top: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
src/asrb_pkg.sv
src/asrb_if.sv
src/asrb_div.sv
src/adaptive_split_ratio_balancer_top.sv
dv/tb_adaptive_split_ratio_balancer_top.sv
